// ----- design/joystick_center_calibrate_and_scale_assert.svh -----
// Assertion macros shared by the joystick calibrate and scale RTL.
`ifndef JOYSTICK_CENTER_CALIBRATE_AND_SCALE_ASSERT_SVH
`define JOYSTICK_CENTER_CALIBRATE_AND_SCALE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle during reset.
`define JCCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jccs assertion failed");
// Next-cycle implication, sampled on clk, idle during reset.
`define JCCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jccs assertion failed");
`else
`define JCCS_ASSERT_NOW(label, ante, cons)
`define JCCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/jccs_pkg.sv -----
// Shared constants, types and register codes of the joystick calibrate and scale block.
`timescale 1ns / 1ps
`default_nettype none

package jccs_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS = 12;
    localparam int TALLY_BITS  = 10;
    localparam int AXES        = 4;
    localparam int AXIS_BITS   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SUM_BITS    = SAMPLE_BITS + TALLY_BITS;
    localparam int RANGE_BITS  = SAMPLE_BITS - 1;
    localparam int PCT_BITS    = 8;
    localparam int PCT_LIMIT   = 100;

    // Divider sizing: a calibration quotient has SAMPLE_BITS bits, a percent
    // quotient needs 7 bits before the clamp to 100
    localparam int CAL_STEPS  = SAMPLE_BITS;
    localparam int READ_STEPS = 7;
    localparam int NUM_BITS   = SUM_BITS;
    localparam int DEN_BITS   = (TALLY_BITS > RANGE_BITS) ? TALLY_BITS : RANGE_BITS;
    localparam int LIM_BITS   = DEN_BITS + CAL_STEPS;
    localparam int CNT_BITS   = $clog2(CAL_STEPS + 1);
    localparam int PROD_BITS  = SAMPLE_BITS + 7;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // APB register file
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_FULL_SCALE = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_CAL_COUNT  = 1'b1;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RST = 12'd4095;
    localparam logic [TALLY_BITS-1:0]  CAL_COUNT_RST  = 10'd100;

    typedef logic [SAMPLE_BITS-1:0] samp_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [RANGE_BITS-1:0]  rng_t;
    typedef logic [PCT_BITS-1:0]    pct_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] full_scale;
        logic [TALLY_BITS-1:0]  cal_count;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic                cal_mode;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 sat;
        logic [CAL_STEPS-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/jccs_if.sv -----
// Valid/ready channel interfaces for joystick sample beats and percent result beats.
`timescale 1ns / 1ps
`default_nettype none

interface jccs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [jccs_pkg::SAMPLE_BITS-1:0]  left_x_sample;
    logic [jccs_pkg::SAMPLE_BITS-1:0]  left_y_sample;
    logic [jccs_pkg::SAMPLE_BITS-1:0]  right_x_sample;
    logic [jccs_pkg::SAMPLE_BITS-1:0]  right_y_sample;

    modport source (
        output valid, func, left_x_sample, left_y_sample, right_x_sample, right_y_sample,
        input  ready
    );
    modport sink (
        input  valid, func, left_x_sample, left_y_sample, right_x_sample, right_y_sample,
        output ready
    );
endinterface

interface jccs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [jccs_pkg::PCT_BITS-1:0] left_x_pct;
    logic signed [jccs_pkg::PCT_BITS-1:0] left_y_pct;
    logic signed [jccs_pkg::PCT_BITS-1:0] right_x_pct;
    logic signed [jccs_pkg::PCT_BITS-1:0] right_y_pct;
    logic                                cal_done;

    modport source (
        output valid, left_x_pct, left_y_pct, right_x_pct, right_y_pct, cal_done,
        input  ready
    );
    modport sink (
        input  valid, left_x_pct, left_y_pct, right_x_pct, right_y_pct, cal_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/jccs_cfg.sv -----
// APB register file holding full scale and calibration count.
`timescale 1ns / 1ps
`default_nettype none

module jccs_cfg (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [jccs_pkg::ADDR_BITS-1:0]      paddr,
    input  wire [jccs_pkg::DATA_BITS-1:0]      pwdata,
    output logic [jccs_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready,
    output jccs_pkg::cfg_t                     cfg
);

    logic [jccs_pkg::SAMPLE_BITS-1:0]  full_scale_reg;
    logic [jccs_pkg::SAMPLE_BITS-1:0]  full_scale_next;
    logic [jccs_pkg::TALLY_BITS-1:0]   cal_count_reg;
    logic [jccs_pkg::TALLY_BITS-1:0]   cal_count_next;
    logic [jccs_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[jccs_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode the write beat
    always_comb
    begin
        full_scale_next = full_scale_reg;
        cal_count_next  = cal_count_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                jccs_pkg::REG_FULL_SCALE: full_scale_next = pwdata[jccs_pkg::SAMPLE_BITS-1:0];
                jccs_pkg::REG_CAL_COUNT:  cal_count_next  = pwdata[jccs_pkg::TALLY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (reg_idx)
            jccs_pkg::REG_FULL_SCALE: prdata = jccs_pkg::DATA_BITS'(full_scale_reg);
            jccs_pkg::REG_CAL_COUNT:  prdata = jccs_pkg::DATA_BITS'(cal_count_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= jccs_pkg::FULL_SCALE_RST;
            cal_count_reg  <= jccs_pkg::CAL_COUNT_RST;
        end
        else
        begin
            full_scale_reg <= full_scale_next;
            cal_count_reg  <= cal_count_next;
        end
    end

    assign cfg.full_scale = full_scale_reg;
    assign cfg.cal_count  = cal_count_reg;

endmodule

`default_nettype wire

// ----- design/jccs_div.sv -----
// Bit-serial restoring divider with a saturation precheck, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module jccs_div (
    input  wire                clk,
    input  wire                rst_n,
    input  jccs_pkg::div_req_t req,
    output jccs_pkg::div_rsp_t rsp
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } dstate_t;

    dstate_t                            state_reg;
    dstate_t                            state_next;
    logic                               done_reg;
    logic                               done_next;
    logic                               sat_reg;
    logic                               sat_next;
    logic [jccs_pkg::NUM_BITS-1:0]      rem_reg;
    logic [jccs_pkg::NUM_BITS-1:0]      rem_next;
    logic [jccs_pkg::NUM_BITS-1:0]      dsh_reg;
    logic [jccs_pkg::NUM_BITS-1:0]      dsh_next;
    logic [jccs_pkg::CAL_STEPS-1:0]     quo_reg;
    logic [jccs_pkg::CAL_STEPS-1:0]     quo_next;
    logic [jccs_pkg::CNT_BITS-1:0]      cnt_reg;
    logic [jccs_pkg::CNT_BITS-1:0]      cnt_next;
    logic [jccs_pkg::LIM_BITS-1:0]      lim;
    logic                               over;
    logic [jccs_pkg::NUM_BITS:0]        diff;

    // Quotient would not fit in the step count: saturate without iterating
    always_comb
    begin
        if (req.cal_mode)
            lim = jccs_pkg::LIM_BITS'({req.den, {jccs_pkg::CAL_STEPS{1'b0}}});
        else
            lim = jccs_pkg::LIM_BITS'({req.den, {jccs_pkg::READ_STEPS{1'b0}}});
        over = jccs_pkg::LIM_BITS'(req.num) >= lim;
    end

    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};

    // Advance one quotient bit per cycle
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    sat_next = over;
                    rem_next = req.num;
                    quo_next = '0;
                    if (req.cal_mode)
                    begin
                        dsh_next = jccs_pkg::NUM_BITS'(
                            {req.den, {(jccs_pkg::CAL_STEPS-1){1'b0}}});
                        cnt_next = jccs_pkg::CNT_BITS'(jccs_pkg::CAL_STEPS);
                    end
                    else
                    begin
                        dsh_next = jccs_pkg::NUM_BITS'(
                            {req.den, {(jccs_pkg::READ_STEPS-1){1'b0}}});
                        cnt_next = jccs_pkg::CNT_BITS'(jccs_pkg::READ_STEPS);
                    end
                    if (over)
                        done_next = 1'b1;
                    else
                        state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (!diff[jccs_pkg::NUM_BITS])
                    rem_next = diff[jccs_pkg::NUM_BITS-1:0];
                quo_next = {quo_reg[jccs_pkg::CAL_STEPS-2:0], !diff[jccs_pkg::NUM_BITS]};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - jccs_pkg::CNT_BITS'(1);
                if (cnt_reg == jccs_pkg::CNT_BITS'(1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ----- design/joystick_center_calibrate_and_scale.sv -----
// Top level: joystick center calibration and percent scaling over a shared serial divider.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+----------------------------------------------
//  in_ch    | in  | valid / ready   | func, left/right x/y samples
//  out_ch   | out | valid / ready   | left/right x/y percent, cal_done
//  apb      | in  | psel / penable  | full_scale (0x0), cal_count (0x4)
//
// One beat is in work at a time; the four axes share one divider that makes one quotient
// bit per cycle. A calibration beat that does not end a run skips the divider. A read beat
// takes 7 quotient bits per axis plus setup, a calibration beat that ends a run takes
// 12 quotient bits per axis. A quotient that saturates skips its bits.
// Reset clears all sums, centers, ranges and held percents; a stalled result waits in the
// output register while the next beat is already taken in.
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_center_calibrate_and_scale_assert.svh"

module joystick_center_calibrate_and_scale (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [jccs_pkg::ADDR_BITS-1:0]  paddr,
    input  wire [jccs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [jccs_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    jccs_in_if.sink                        in_ch,
    jccs_out_if.source                     out_ch
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    jccs_pkg::cfg_t     cfg;
    jccs_pkg::div_req_t div_req;
    jccs_pkg::div_rsp_t div_rsp;

    state_t                            state_reg;
    state_t                            state_next;
    logic                              func_reg;
    logic                              func_next;
    jccs_pkg::samp_t                   sample_reg [jccs_pkg::AXES];
    jccs_pkg::samp_t                   sample_next [jccs_pkg::AXES];
    jccs_pkg::sum_t                    sum_reg [jccs_pkg::AXES];
    jccs_pkg::sum_t                    sum_next [jccs_pkg::AXES];
    jccs_pkg::samp_t                   offset_reg [jccs_pkg::AXES];
    jccs_pkg::samp_t                   offset_next [jccs_pkg::AXES];
    jccs_pkg::rng_t                    range_reg [jccs_pkg::AXES];
    jccs_pkg::rng_t                    range_next [jccs_pkg::AXES];
    jccs_pkg::pct_t                    held_reg [jccs_pkg::AXES];
    jccs_pkg::pct_t                    held_next [jccs_pkg::AXES];
    jccs_pkg::pct_t                    out_pct_reg [jccs_pkg::AXES];
    jccs_pkg::pct_t                    out_pct_next [jccs_pkg::AXES];
    logic [jccs_pkg::TALLY_BITS-1:0]   tally_reg;
    logic [jccs_pkg::TALLY_BITS-1:0]   tally_next;
    logic [jccs_pkg::AXIS_BITS-1:0]    axis_reg;
    logic [jccs_pkg::AXIS_BITS-1:0]    axis_next;
    logic                              done_reg;
    logic                              done_next;
    logic [jccs_pkg::NUM_BITS-1:0]     num_reg;
    logic [jccs_pkg::NUM_BITS-1:0]     num_next;
    logic [jccs_pkg::DEN_BITS-1:0]     den_reg;
    logic [jccs_pkg::DEN_BITS-1:0]     den_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic                              zero_reg;
    logic                              zero_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_done_reg;
    logic                              out_done_next;

    jccs_pkg::samp_t                   sample_in [jccs_pkg::AXES];
    logic                              in_accept;
    logic                              out_load;
    logic [jccs_pkg::TALLY_BITS-1:0]   count_eff;
    logic [jccs_pkg::TALLY_BITS:0]     tally_inc;
    jccs_pkg::samp_t                   cur_sample;
    jccs_pkg::samp_t                   cur_off;
    logic                              cur_neg;
    jccs_pkg::samp_t                   cur_mag;
    logic [jccs_pkg::PROD_BITS-1:0]    cur_prod;
    jccs_pkg::samp_t                   cal_off;
    jccs_pkg::samp_t                   cal_up;
    jccs_pkg::samp_t                   cal_rng;
    logic [jccs_pkg::READ_STEPS-1:0]   rd_q;
    jccs_pkg::pct_t                    rd_mag;
    jccs_pkg::pct_t                    rd_pct;
    logic                              last_axis;

    jccs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jccs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_in[0] = in_ch.left_x_sample;
    assign sample_in[1] = in_ch.left_y_sample;
    assign sample_in[2] = in_ch.right_x_sample;
    assign sample_in[3] = in_ch.right_y_sample;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    // Load the output register once the beat is finished and the register is free
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // A zero count behaves as a count of one
    assign count_eff = (cfg.cal_count == '0) ? jccs_pkg::TALLY_BITS'(1) : cfg.cal_count;
    assign tally_inc = {1'b0, tally_reg} + (jccs_pkg::TALLY_BITS + 1)'(1);
    assign last_axis = (axis_reg == jccs_pkg::AXIS_BITS'(jccs_pkg::AXES - 1));

    // Deflection of the current axis, scaled by 100 as 64 + 32 + 4
    always_comb
    begin
        cur_sample = sample_reg[axis_reg];
        cur_off    = offset_reg[axis_reg];
        cur_neg    = cur_sample < cur_off;
        cur_mag    = cur_neg ? cur_off - cur_sample : cur_sample - cur_off;
        cur_prod   = (jccs_pkg::PROD_BITS'(cur_mag) << 6)
                   + (jccs_pkg::PROD_BITS'(cur_mag) << 5)
                   + (jccs_pkg::PROD_BITS'(cur_mag) << 2);
    end

    // Turn a divider result into a center and range, or into a clamped percent
    always_comb
    begin
        cal_off = div_rsp.sat ? jccs_pkg::SAMPLE_MAX : div_rsp.quo;
        cal_up  = (cfg.full_scale > cal_off) ? cfg.full_scale - cal_off : '0;
        cal_rng = (cal_off < cal_up) ? cal_off : cal_up;
        rd_q    = div_rsp.quo[jccs_pkg::READ_STEPS-1:0];
        if (div_rsp.sat || rd_q > jccs_pkg::READ_STEPS'(jccs_pkg::PCT_LIMIT))
            rd_mag = jccs_pkg::PCT_BITS'(jccs_pkg::PCT_LIMIT);
        else
            rd_mag = jccs_pkg::PCT_BITS'(rd_q);
        rd_pct = neg_reg ? jccs_pkg::PCT_BITS'(0) - rd_mag : rd_mag;
    end

    // Divider request
    always_comb
    begin
        div_req.start    = (state_reg == S_START);
        div_req.cal_mode = !func_reg;
        div_req.num      = num_reg;
        div_req.den      = den_reg;
    end

    // Sequence one beat over the axes
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        sample_next    = sample_reg;
        sum_next       = sum_reg;
        offset_next    = offset_reg;
        range_next     = range_reg;
        held_next      = held_reg;
        out_pct_next   = out_pct_reg;
        tally_next     = tally_reg;
        axis_next      = axis_reg;
        done_next      = done_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_done_next  = out_done_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next   = in_ch.func;
                    sample_next = sample_in;
                    axis_next   = '0;
                    done_next   = 1'b0;
                    if (!in_ch.func)
                    begin
                        for (int i = 0; i < jccs_pkg::AXES; i++)
                            sum_next[i] = sum_reg[i] + jccs_pkg::SUM_BITS'(sample_in[i]);
                        if (tally_inc >= {1'b0, count_eff})
                        begin
                            done_next  = 1'b1;
                            state_next = S_PREP;
                        end
                        else
                        begin
                            tally_next = tally_inc[jccs_pkg::TALLY_BITS-1:0];
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                if (!func_reg)
                begin
                    num_next = sum_reg[axis_reg];
                    den_next = jccs_pkg::DEN_BITS'(count_eff);
                end
                else
                begin
                    num_next = jccs_pkg::NUM_BITS'(cur_prod);
                    den_next = jccs_pkg::DEN_BITS'(range_reg[axis_reg]);
                end
                neg_next   = cur_neg;
                zero_next  = (cur_sample == cur_off);
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!func_reg)
                    begin
                        offset_next[axis_reg] = cal_off;
                        range_next[axis_reg]  = cal_rng[jccs_pkg::RANGE_BITS-1:0];
                        sum_next[axis_reg]    = '0;
                        if (last_axis)
                            tally_next = '0;
                    end
                    else if (!zero_reg)
                    begin
                        held_next[axis_reg] = rd_pct;
                    end
                    if (last_axis)
                        state_next = S_DONE;
                    else
                    begin
                        axis_next  = axis_reg + jccs_pkg::AXIS_BITS'(1);
                        state_next = S_PREP;
                    end
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_load)
                begin
                    out_pct_next   = held_reg;
                    out_done_next  = done_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < jccs_pkg::AXES; i++)
            begin
                sum_reg[i]    <= '0;
                offset_reg[i] <= '0;
                range_reg[i]  <= '0;
                held_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            range_reg     <= range_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        sample_reg   <= sample_next;
        out_pct_reg  <= out_pct_next;
        axis_reg     <= axis_next;
        done_reg     <= done_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        out_done_reg <= out_done_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_x_pct  = out_pct_reg[0];
    assign out_ch.left_y_pct  = out_pct_reg[1];
    assign out_ch.right_x_pct = out_pct_reg[2];
    assign out_ch.right_y_pct = out_pct_reg[3];
    assign out_ch.cal_done    = out_done_reg;

    // Checks on sequencing
    `JCCS_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_reg != S_IDLE)
    `JCCS_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_reg == S_WAIT)
    `JCCS_ASSERT_NEXT(a_done_loads_output, out_load, out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for joystick center calibration and percent scaling.
`timescale 1ns / 1ps

module tb;
    import jccs_pkg::*;

    localparam logic FUNC_CAL  = 1'b0;
    localparam logic FUNC_READ = 1'b1;
    localparam int   LIMIT_NS  = 8_000_000;
    localparam int   SAMP_TOP  = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic                    func;
        samp_t [AXES-1:0]        smp;
    } joy_beat_t;

    typedef struct packed {
        pct_t [AXES-1:0] pct;
        logic            done;
    } pct_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    wire  [DATA_BITS-1:0] prdata;
    wire                  pready;

    jccs_in_if  in_ch ();
    jccs_out_if out_ch ();

    joystick_center_calibrate_and_scale u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Stimulus feed, expected percents and bookkeeping
    joy_beat_t pend_beats [$];
    pct_beat_t pct_expect_q [$];
    joy_beat_t cur_beat;
    pct_beat_t seen_beat;
    pct_beat_t want_beat;
    int        beats_queued;
    int        results_seen;
    int        err_cnt;
    int        send_idle_pct;
    int        recv_idle_pct;
    string     axis_name [AXES] = '{"left_x", "left_y", "right_x", "right_y"};

    // Register mirror
    samp_t                 fs_cfg;
    logic [TALLY_BITS-1:0] cc_cfg;

    // Calibration and scaling state mirror
    sum_t                  acc_sum  [AXES];
    logic [TALLY_BITS-1:0] cal_seen;
    samp_t                 ctr_code [AXES];
    rng_t                  travel   [AXES];
    pct_t                  pct_hold [AXES];

    // Percent deflection of one axis; a centered sample keeps the last value
    function automatic pct_t scale_pct(samp_t s, samp_t c, rng_t span, pct_t prev);
        logic        neg;
        int unsigned mag;
        int unsigned q;
        if (s == c)
            return prev;
        neg = (s < c);
        mag = neg ? (c - s) : (s - c);
        if (span == '0)
            q = PCT_LIMIT;
        else
        begin
            q = (PCT_LIMIT * mag) / span;
            if (q > PCT_LIMIT)
                q = PCT_LIMIT;
        end
        return neg ? pct_t'(-int'(q)) : pct_t'(q);
    endfunction

    // Advance the state mirror by one accepted beat and queue its percents
    function automatic void predict_beat(joy_beat_t b);
        pct_beat_t   r;
        int unsigned div;
        int unsigned ctr;
        int unsigned up;
        r = '0;
        if (b.func == FUNC_CAL)
        begin
            div = (cc_cfg == '0) ? 1 : cc_cfg;
            for (int a = 0; a < AXES; a++)
                acc_sum[a] = acc_sum[a] + b.smp[a];
            if (int'(cal_seen) + 1 >= div)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    ctr = acc_sum[a] / div;
                    if (ctr > SAMP_TOP)
                        ctr = SAMP_TOP;
                    up = (fs_cfg > ctr) ? (fs_cfg - ctr) : 0;
                    ctr_code[a] = samp_t'(ctr);
                    travel[a]   = rng_t'((ctr < up) ? ctr : up);
                    acc_sum[a]  = '0;
                end
                cal_seen = '0;
                r.done   = 1'b1;
            end
            else
                cal_seen = cal_seen + 1'b1;
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
                pct_hold[a] = scale_pct(b.smp[a], ctr_code[a], travel[a], pct_hold[a]);
        end
        for (int a = 0; a < AXES; a++)
            r.pct[a] = pct_hold[a];
        pct_expect_q.push_back(r);
    endfunction

    function automatic samp_t near(samp_t mid, int spread);
        int v;
        v = int'(mid) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > SAMP_TOP)
            v = SAMP_TOP;
        return samp_t'(v);
    endfunction

    // Read samples lean on the center and the code extremes
    function automatic samp_t pick_read(samp_t mid);
        case ($urandom_range(7))
            0: return '0;
            1: return samp_t'(SAMP_TOP);
            2: return mid;
            3, 4: return near(mid, 3);
            default: return samp_t'($urandom_range(SAMP_TOP));
        endcase
    endfunction

    task automatic push_beat(input logic f, input samp_t [AXES-1:0] s);
        joy_beat_t b;
        b.func = f;
        b.smp  = s;
        pend_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push4(input logic f, input samp_t lx, input samp_t ly,
                         input samp_t rx, input samp_t ry);
        push_beat(f, {ry, rx, ly, lx});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen != beats_queued);
    endtask

    // APB write: setup beat, then access beat
    task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FULL_SCALE)
            fs_cfg = val[SAMPLE_BITS-1:0];
        else
            cc_cfg = val[TALLY_BITS-1:0];
    endtask

    task automatic set_cfg(input int fs, input int cc);
        reg_write(REG_FULL_SCALE, DATA_BITS'(fs));
        reg_write(REG_CAL_COUNT, DATA_BITS'(cc));
        @(negedge clk);
    endtask

    // Calibration runs followed by reads, single reads and stray beats, mixed at random
    task automatic feed_mix(input int n);
        int               made;
        int               run_len;
        int               reads;
        int               roll;
        samp_t            mid [AXES];
        samp_t [AXES-1:0] s;
        made = 0;
        for (int a = 0; a < AXES; a++)
            mid[a] = samp_t'($urandom_range(SAMP_TOP));
        while (made < n)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    case ($urandom_range(9))
                        0: mid[a] = '0;
                        1: mid[a] = samp_t'(SAMP_TOP);
                        default: mid[a] = samp_t'($urandom_range(SAMP_TOP));
                    endcase
                end
                run_len = (cc_cfg == '0) ? 1 : cc_cfg;
                if (run_len > 24)
                    run_len = $urandom_range(24, 1);
                for (int k = 0; k < run_len; k++)
                begin
                    for (int a = 0; a < AXES; a++)
                        s[a] = near(mid[a], 8);
                    push_beat(FUNC_CAL, s);
                    made++;
                end
                reads = $urandom_range(10, 2);
                for (int k = 0; k < reads; k++)
                begin
                    for (int a = 0; a < AXES; a++)
                        s[a] = pick_read(mid[a]);
                    push_beat(FUNC_READ, s);
                    made++;
                end
            end
            else if (roll < 85)
            begin
                for (int a = 0; a < AXES; a++)
                    s[a] = pick_read(mid[a]);
                push_beat(FUNC_READ, s);
                made++;
            end
            else
            begin
                for (int a = 0; a < AXES; a++)
                    s[a] = samp_t'($urandom_range(SAMP_TOP));
                push_beat(logic'($urandom_range(1)), s);
                made++;
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample driver: present the next pending beat, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.func           <= 1'b0;
            in_ch.left_x_sample  <= '0;
            in_ch.left_y_sample  <= '0;
            in_ch.right_x_sample <= '0;
            in_ch.right_y_sample <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_beat(cur_beat);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pend_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_beat = pend_beats.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.func           <= cur_beat.func;
                    in_ch.left_x_sample  <= cur_beat.smp[0];
                    in_ch.left_y_sample  <= cur_beat.smp[1];
                    in_ch.right_x_sample <= cur_beat.smp[2];
                    in_ch.right_y_sample <= cur_beat.smp[3];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: stall at random, compare each beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen_beat.pct[0] = out_ch.left_x_pct;
                seen_beat.pct[1] = out_ch.left_y_pct;
                seen_beat.pct[2] = out_ch.right_x_pct;
                seen_beat.pct[3] = out_ch.right_y_pct;
                seen_beat.done   = out_ch.cal_done;
                results_seen++;
                if (pct_expect_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result beat, got %h", $time, seen_beat);
                end
                else
                begin
                    want_beat = pct_expect_q.pop_front();
                    for (int a = 0; a < AXES; a++)
                    begin
                        if (seen_beat.pct[a] !== want_beat.pct[a])
                        begin
                            err_cnt++;
                            $display("%0t: %s_pct expected %0d got %0d", $time, axis_name[a],
                                     $signed(want_beat.pct[a]), $signed(seen_beat.pct[a]));
                        end
                    end
                    if (seen_beat.done !== want_beat.done)
                    begin
                        err_cnt++;
                        $display("%0t: cal_done expected %0b got %0b", $time,
                                 want_beat.done, seen_beat.done);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run limit
    initial
    begin
        #LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

    // Sequence: reset, directed cases, then random phases
    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.func           = 1'b0;
        in_ch.left_x_sample  = '0;
        in_ch.left_y_sample  = '0;
        in_ch.right_x_sample = '0;
        in_ch.right_y_sample = '0;
        out_ch.ready         = 1'b0;
        beats_queued         = 0;
        results_seen         = 0;
        err_cnt              = 0;
        send_idle_pct        = 30;
        recv_idle_pct        = 85;
        fs_cfg               = FULL_SCALE_RST;
        cc_cfg               = CAL_COUNT_RST;
        cal_seen             = '0;
        for (int a = 0; a < AXES; a++)
        begin
            acc_sum[a]  = '0;
            ctr_code[a] = '0;
            travel[a]   = '0;
            pct_hold[a] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reads before any calibration: zero range saturates, centered holds
        push4(FUNC_READ, 12'd0, 12'd0, 12'd4095, 12'd4095);
        push4(FUNC_READ, 12'd0, 12'd4095, 12'd0, 12'd1);
        // Partial run interrupted by a read
        push4(FUNC_CAL, 12'd4095, 12'd4095, 12'd0, 12'd4095);
        push4(FUNC_READ, 12'd1, 12'd2, 12'd3, 12'd4);
        push4(FUNC_CAL, 12'd4095, 12'd4095, 12'd0, 12'd4095);
        wait_drained();

        // Zero count below the tally: next sample ends the run, centers saturate except right_x, whose sum is zero
        set_cfg(4095, 0);
        push4(FUNC_CAL, 12'd4095, 12'd2000, 12'd0, 12'd100);
        push4(FUNC_READ, 12'd0, 12'd4095, 12'd1, 12'd4095);
        wait_drained();

        // Small full scale: centers above it get no travel
        set_cfg(1000, 2);
        push4(FUNC_CAL, 12'd3000, 12'd500, 12'd2047, 12'd0);
        push4(FUNC_CAL, 12'd3002, 12'd501, 12'd2048, 12'd0);
        push4(FUNC_READ, 12'd3001, 12'd500, 12'd2047, 12'd0);
        push4(FUNC_READ, 12'd0, 12'd0, 12'd4095, 12'd1);
        push4(FUNC_READ, 12'd4095, 12'd1000, 12'd0, 12'd4095);
        push4(FUNC_READ, 12'd2000, 12'd499, 12'd2047, 12'd0);
        wait_drained();

        // Single-sample calibration, then clamp and truncation reads
        set_cfg(4095, 1);
        push4(FUNC_CAL, 12'd2047, 12'd1024, 12'd3000, 12'd1);
        push4(FUNC_READ, 12'd0, 12'd0, 12'd4095, 12'd0);
        push4(FUNC_READ, 12'd2048, 12'd1025, 12'd2999, 12'd2);
        push4(FUNC_READ, 12'd4095, 12'd2048, 12'd3547, 12'd4095);
        push4(FUNC_READ, 12'd1500, 12'd500, 12'd3500, 12'd1);
        wait_drained();

        // Sender mostly busy, receiver mostly stalled
        set_cfg(4095, 1023);
        feed_mix(80);
        wait_drained();
        set_cfg($urandom_range(4095, 1), $urandom_range(8, 1));
        feed_mix(100);
        wait_drained();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 85;
        recv_idle_pct = 30;
        set_cfg(1, 1);
        feed_mix(100);
        wait_drained();
        set_cfg($urandom_range(4095, 1), $urandom_range(16, 2));
        feed_mix(100);
        wait_drained();

        // No idling on either side; hold the sender once until all results are in
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_cfg(4095, $urandom_range(6, 1));
        feed_mix(100);
        wait_drained();
        feed_mix(100);
        wait_drained();

        repeat (100) @(posedge clk);
        if (err_cnt == 0 && pct_expect_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
